>>> rtl/tllm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tllm_pkg: shared types and constants of the three-list linked mover
// Field widths, operation codes, and the command and status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package tllm_pkg;

    localparam int FIELD_W = 11;

    localparam logic [1:0] OP_MOVE_B  = 2'd0;
    localparam logic [1:0] OP_MOVE_C  = 2'd1;
    localparam logic [1:0] OP_READ    = 2'd2;
    localparam logic [1:0] OP_REBUILD = 2'd3;

    typedef struct packed {
        logic accept;
        logic lookup;
        logic unlink;
        logic link_src;
        logic link_nbr;
        logic build_clr;
        logic build_step;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic is_move;
        logic is_rebuild;
        logic ok;
        logic build_last;
        logic out_free;
    } sts_t;

endpackage
`default_nettype wire

>>> rtl/tllm_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tllm_datapath: link tables, operand registers and result register
// Holds the prev and next link memories, the item count, the rebuild sweep
// counter and the output beat register, and carries out controller commands.
// ----------------------------------------------------------------------------
module tllm_datapath #(
    parameter int MAX_ITEMS = 1024
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [1:0]                    s_op,
    input  wire logic [tllm_pkg::FIELD_W-1:0]  s_item_id,
    input  wire logic                          cfg_wr,
    input  wire logic [tllm_pkg::FIELD_W-1:0]  cfg_data,
    input  wire tllm_pkg::cmd_t                cmd,
    output tllm_pkg::sts_t                     sts,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_status,
    output logic [tllm_pkg::FIELD_W-1:0]       m_prev_link,
    output logic [tllm_pkg::FIELD_W-1:0]       m_next_link
);

    localparam int FW         = tllm_pkg::FIELD_W;
    localparam int DEPTH      = MAX_ITEMS + 3;
    localparam int LW         = $clog2(DEPTH);
    localparam int CW         = ((LW > FW) ? LW : FW) + 1;
    localparam int ICNT_RST_I = (MAX_ITEMS < 1024) ? MAX_ITEMS : 1024;

    logic [LW-1:0] prev_mem [DEPTH];
    logic [LW-1:0] next_mem [DEPTH];

    logic [FW-1:0] item_count_reg;
    logic [1:0]    op_reg;
    logic [FW-1:0] id_reg;
    logic [LW-1:0] p_reg;
    logic [LW-1:0] q_reg;
    logic [LW-1:0] t_reg;
    logic [LW-1:0] build_idx_reg;
    logic [LW-1:0] prev_rd_reg;
    logic [LW-1:0] next_rd_reg;
    logic          m_valid_reg;
    logic          m_status_reg;
    logic [FW-1:0] m_prev_reg;
    logic [FW-1:0] m_next_reg;

    logic [FW-1:0] cfg_val;
    logic [LW-1:0] n;
    logic [LW-1:0] n_b;
    logic [LW-1:0] n_c;
    logic [LW-1:0] head;
    logic [LW-1:0] src;
    logic [LW-1:0] t_val;
    logic [CW-1:0] id_w;
    logic [CW-1:0] n_w;
    logic          is_move;
    logic          ok;

    logic          prev_we;
    logic [LW-1:0] prev_wa;
    logic [LW-1:0] prev_wd;
    logic          prev_re;
    logic [LW-1:0] prev_ra;
    logic          next_we;
    logic [LW-1:0] next_wa;
    logic [LW-1:0] next_wd;
    logic          next_re;
    logic [LW-1:0] next_ra;

    assign n       = LW'(item_count_reg);
    assign n_b     = n + LW'(1);
    assign n_c     = n + LW'(2);
    assign head    = (op_reg == tllm_pkg::OP_MOVE_C) ? n_c : n_b;
    assign src     = LW'(id_reg);
    assign id_w    = CW'(id_reg);
    assign n_w     = CW'(item_count_reg);
    assign is_move = (op_reg == tllm_pkg::OP_MOVE_B) || (op_reg == tllm_pkg::OP_MOVE_C);
    assign ok      = is_move ? ((id_w != '0) && (id_w <= n_w)) : (id_w <= n_w + CW'(2));
    // prev[head] was read in the same cycle as the unlink write; bypass it
    assign t_val   = (q_reg == head) ? p_reg : prev_rd_reg;

    assign cfg_val = (cfg_data == '0) ? FW'(1) :
                     ((32'(cfg_data) > MAX_ITEMS) ? FW'(MAX_ITEMS) : cfg_data);

    assign sts.is_move    = is_move;
    assign sts.is_rebuild = (op_reg == tllm_pkg::OP_REBUILD);
    assign sts.ok         = ok;
    assign sts.build_last = (build_idx_reg == n_c);
    assign sts.out_free   = !m_valid_reg || m_ready;

    always_comb begin
        prev_we = 1'b0;
        prev_wa = '0;
        prev_wd = '0;
        prev_re = 1'b0;
        prev_ra = '0;
        next_we = 1'b0;
        next_wa = '0;
        next_wd = '0;
        next_re = 1'b0;
        next_ra = '0;
        if (cmd.build_step) begin
            prev_we = 1'b1;
            next_we = 1'b1;
            prev_wa = build_idx_reg;
            next_wa = build_idx_reg;
            if (build_idx_reg == '0) begin
                prev_wd = n;
            end else if (build_idx_reg <= n) begin
                prev_wd = build_idx_reg - LW'(1);
            end else begin
                prev_wd = build_idx_reg;
            end
            if (build_idx_reg == n) begin
                next_wd = '0;
            end else if (build_idx_reg < n) begin
                next_wd = build_idx_reg + LW'(1);
            end else begin
                next_wd = build_idx_reg;
            end
        end else if (cmd.lookup) begin
            prev_re = 1'b1;
            prev_ra = src;
            next_re = 1'b1;
            next_ra = src;
        end else if (cmd.unlink) begin
            next_we = 1'b1;
            next_wa = prev_rd_reg;
            next_wd = next_rd_reg;
            prev_we = 1'b1;
            prev_wa = next_rd_reg;
            prev_wd = prev_rd_reg;
            prev_re = 1'b1;
            prev_ra = head;
        end else if (cmd.link_src) begin
            prev_we = 1'b1;
            prev_wa = src;
            prev_wd = t_val;
            next_we = 1'b1;
            next_wa = src;
            next_wd = head;
        end else if (cmd.link_nbr) begin
            next_we = 1'b1;
            next_wa = t_reg;
            next_wd = src;
            prev_we = 1'b1;
            prev_wa = head;
            prev_wd = src;
        end
    end

    always_ff @(posedge aclk) begin
        if (prev_we) begin
            prev_mem[prev_wa] <= prev_wd;
        end
        if (prev_re) begin
            prev_rd_reg <= prev_mem[prev_ra];
        end
    end

    always_ff @(posedge aclk) begin
        if (next_we) begin
            next_mem[next_wa] <= next_wd;
        end
        if (next_re) begin
            next_rd_reg <= next_mem[next_ra];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_count_reg <= FW'(ICNT_RST_I);
            build_idx_reg  <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr) begin
                item_count_reg <= cfg_val;
            end
            if (cfg_wr || cmd.build_clr) begin
                build_idx_reg <= '0;
            end else if (cmd.build_step) begin
                build_idx_reg <= build_idx_reg + LW'(1);
            end
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            op_reg <= s_op;
            id_reg <= s_item_id;
        end
        if (cmd.unlink) begin
            p_reg <= prev_rd_reg;
            q_reg <= next_rd_reg;
        end
        if (cmd.link_src) begin
            t_reg <= t_val;
        end
        if (cmd.load_out) begin
            m_status_reg <= (ok || (op_reg == tllm_pkg::OP_REBUILD)) ? 1'b0 : 1'b1;
            if (!ok) begin
                m_prev_reg <= '0;
                m_next_reg <= '0;
            end else if (is_move) begin
                m_prev_reg <= FW'(t_reg);
                m_next_reg <= FW'(head);
            end else begin
                m_prev_reg <= FW'(prev_rd_reg);
                m_next_reg <= FW'(next_rd_reg);
            end
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_prev_link = m_prev_reg;
    assign m_next_link = m_next_reg;

endmodule
`default_nettype wire

>>> rtl/tllm_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tllm_ctrl: operation sequencer of the three-list linked mover
// Steps each operation through its table reads and writes, runs the rebuild
// sweep after reset, configuration and rebuild requests, and hands results
// to the output register.
// ----------------------------------------------------------------------------
module tllm_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire logic           cfg_wr,
    input  wire tllm_pkg::sts_t sts,
    output tllm_pkg::cmd_t      cmd
);

    localparam logic [3:0] ST_INIT     = 4'd0;
    localparam logic [3:0] ST_IDLE     = 4'd1;
    localparam logic [3:0] ST_DECODE   = 4'd2;
    localparam logic [3:0] ST_BUILD    = 4'd3;
    localparam logic [3:0] ST_LOOKUP   = 4'd4;
    localparam logic [3:0] ST_UNLINK   = 4'd5;
    localparam logic [3:0] ST_LINK_SRC = 4'd6;
    localparam logic [3:0] ST_LINK_NBR = 4'd7;
    localparam logic [3:0] ST_DONE     = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_INIT: begin
                cmd.build_step = 1'b1;
                if (sts.build_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (sts.is_rebuild) begin
                    cmd.build_clr = 1'b1;
                    state_next    = ST_BUILD;
                end else if (sts.ok) begin
                    state_next = ST_LOOKUP;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_BUILD: begin
                cmd.build_step = 1'b1;
                if (sts.build_last) begin
                    state_next = sts.ok ? ST_LOOKUP : ST_DONE;
                end
            end
            ST_LOOKUP: begin
                cmd.lookup = 1'b1;
                state_next = sts.is_move ? ST_UNLINK : ST_DONE;
            end
            ST_UNLINK: begin
                cmd.unlink = 1'b1;
                state_next = ST_LINK_SRC;
            end
            ST_LINK_SRC: begin
                cmd.link_src = 1'b1;
                state_next   = ST_LINK_NBR;
            end
            ST_LINK_NBR: begin
                cmd.link_nbr = 1'b1;
                state_next   = ST_DONE;
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        if (cfg_wr) begin
            state_next = ST_INIT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

>>> rtl/three_list_linked_mover.sv
`default_nettype none
// ----------------------------------------------------------------------------
// three_list_linked_mover: three circular doubly linked lists in link tables
// Items 1..item_count live in lists A, B and C with sentinels 0, n+1, n+2.
// Moves to the tail of B or C, link reads and rebuilds on one input channel.
// ----------------------------------------------------------------------------
// Usage
//   s_ channel: one beat per operation (s_op, s_item_id), valid/ready.
//   m_ channel: one beat per operation (m_status, m_prev_link, m_next_link).
//   cfg channel: writes item_count (clamped to 1..MAX_ITEMS); cfg_ready is
//   always high and a write starts a rebuild of the tables.
//   One operation is worked at a time. After accept a read steps through
//     decode, lookup and done, a move adds unlink, link_src and link_nbr,
//     a rebuild sweeps the tables first (then done when item_id lies past
//     node item_count+2), and an out-of-range item goes straight to done.
//   s_ready rises with m_valid. Step count is set by the single read and
//   write port of each link table: a move needs four dependent table steps,
//   a rebuild writes one entry per cycle over nodes 0..item_count+2.
//   Reset: item_count returns to min(1024, MAX_ITEMS) and a rebuild sweep over
//   nodes 0..item_count+2 runs with s_ready low.
//   Receiver stall: the result waits in the output register; the block holds
//   the next finished result until the register frees up.
// ----------------------------------------------------------------------------
module three_list_linked_mover #(
    parameter int MAX_ITEMS = 1024
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [1:0]                    s_op,
    input  wire logic [tllm_pkg::FIELD_W-1:0]  s_item_id,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [tllm_pkg::FIELD_W-1:0]  cfg_data,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_status,
    output logic [tllm_pkg::FIELD_W-1:0]       m_prev_link,
    output logic [tllm_pkg::FIELD_W-1:0]       m_next_link
);

    tllm_pkg::cmd_t cmd;
    tllm_pkg::sts_t sts;
    logic           cfg_wr;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    tllm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cfg_wr  (cfg_wr),
        .sts     (sts),
        .cmd     (cmd)
    );

    tllm_datapath #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_op        (s_op),
        .s_item_id   (s_item_id),
        .cfg_wr      (cfg_wr),
        .cfg_data    (cfg_data),
        .cmd         (cmd),
        .sts         (sts),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_prev_link (m_prev_link),
        .m_next_link (m_next_link)
    );

endmodule
`default_nettype wire
